// ===== hdl/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// chr_pkg: shared types and constants of the hash ring
// operation and status codes, word layouts
// ----------------------------------------------------------------------------
`default_nettype none

package chr_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ID_EXISTS = 3'd1;
    localparam logic [2:0] ST_COLLISION = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ABSENT    = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    localparam int HASH_W  = 31;
    localparam int ID_W    = 32;
    localparam int ENTRY_W = HASH_W + ID_W;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [30:0]        key_hash;
        logic [30:0]        owner_hash;
        logic signed [31:0] owner_id;
        logic [6:0]         machine_count;
    } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/chr_if.sv =====
// ----------------------------------------------------------------------------
// chr_if: valid/ready channel
// carries one word per accepted handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface chr_in_if;
    import chr_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chr_out_if;
    import chr_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/consistent_hash_ring_top.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_top: sorted ring of machine hashes and ids
// add, remove and successor lookup over a ram held ring
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  cmd       in   operation, key
//  rsp       out  status, key_hash, owner_hash, owner_id, machine_count
//
//  one word at a time: hashing, then a scan of the ring through the ram read
//  port, one entry a cycle, a decision state, then a shift pass for
//  add/remove, each entry moved by a read then a write, or a read and a wait
//  for a lookup, and a hand-over to the output register.
//  reset clears the state, the count and the valid flags; the ram needs no clearing.
//  a finished word waits in a result register while the output register is full;
//  the next word is accepted only once it has moved into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_top
    import chr_pkg::*;
#(
    parameter int RING_SLOTS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    chr_in_if.sink    cmd,
    chr_out_if.source rsp
);

    localparam int AW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
    localparam int CW = $clog2(RING_SLOTS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HASH  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_MVRD  = 4'd4;
    localparam logic [3:0] S_MVWR  = 4'd5;
    localparam logic [3:0] S_LKRD  = 4'd6;
    localparam logic [3:0] S_LKWT  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]  op_reg, op_next;
    logic [31:0] key_reg, key_next;
    logic [30:0] h_reg, h_next;
    logic [CW-1:0] idx_reg, idx_next;      // scan address issued
    logic [CW-1:0] pos_reg, pos_next;      // first hash >= h
    logic        pos_found_reg, pos_found_next;
    logic        hcol_reg, hcol_next;
    logic [CW-1:0] fid_reg, fid_next;
    logic        fid_found_reg, fid_found_next;
    logic        chk_reg, chk_next;        // read data valid for idx-1
    logic [CW-1:0] mv_reg, mv_next;
    logic        ovalid_reg, ovalid_next;
    out_word_t   odata_reg, odata_next;
    out_word_t   res_reg, res_next;

    logic          hstart, hdone;
    logic [30:0]   hval;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [ENTRY_W-1:0] wdata, rdata;
    logic [30:0]   rd_h;
    logic [31:0]   rd_id;
    logic [CW-1:0] chk_idx;

    chr_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hstart),
        .key   (key_reg),
        .done  (hdone),
        .hash  (hval)
    );

    chr_ram #(.WIDTH(ENTRY_W), .DEPTH(RING_SLOTS)) u_ring (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_h    = rdata[ENTRY_W-1:ID_W];
    assign rd_id   = rdata[ID_W-1:0];
    assign chk_idx = idx_reg - CW'(1);
    assign cmd.ready = (state_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = odata_reg;

    function automatic out_word_t mk(input logic [2:0] st, input logic [30:0] kh,
                                     input logic [30:0] oh, input logic [31:0] oi,
                                     input logic [CW-1:0] c);
        out_word_t w;
        w.status        = st;
        w.key_hash      = kh;
        w.owner_hash    = oh;
        w.owner_id      = oi;
        w.machine_count = 7'(c);
        return w;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        h_next         = h_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        pos_found_next = pos_found_reg;
        hcol_next      = hcol_reg;
        fid_next       = fid_reg;
        fid_found_next = fid_found_reg;
        chk_next       = 1'b0;
        mv_next        = mv_reg;
        ovalid_next    = ovalid_reg && !rsp.ready;
        odata_next     = odata_reg;
        res_next       = res_reg;
        hstart         = 1'b0;
        we             = 1'b0;
        waddr          = AW'(mv_reg);
        wdata          = {hval, key_reg};
        raddr          = AW'(idx_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    op_next    = cmd.data.operation;
                    key_next   = cmd.data.key;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                hstart         = 1'b1;
                idx_next       = '0;
                pos_found_next = 1'b0;
                hcol_next      = 1'b0;
                fid_found_next = 1'b0;
                pos_next       = count_reg;
                fid_next       = count_reg;
                if (hdone)
                begin
                    h_next     = hval;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // data from the address issued last cycle
                if (chk_reg)
                begin
                    if (!pos_found_reg && rd_h >= h_reg)
                    begin
                        pos_found_next = 1'b1;
                        pos_next       = chk_idx;
                        hcol_next      = (rd_h == h_reg);
                    end
                    if (!fid_found_reg && rd_id == key_reg)
                    begin
                        fid_found_next = 1'b1;
                        fid_next       = chk_idx;
                    end
                end
                if (idx_reg < count_reg)
                begin
                    chk_next = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
                else if (!chk_reg || idx_reg == count_reg)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (fid_found_reg)
                        begin
                            res_next   = mk(ST_ID_EXISTS, h_reg, '0, '0, count_reg);
                            state_next = S_OUT;
                        end
                        else if (pos_found_reg && hcol_reg)
                        begin
                            res_next   = mk(ST_COLLISION, h_reg, '0, '0, count_reg);
                            state_next = S_OUT;
                        end
                        else if (count_reg >= CW'(RING_SLOTS))
                        begin
                            res_next   = mk(ST_FULL, h_reg, '0, '0, count_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            mv_next    = count_reg;
                            state_next = S_MVRD;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!fid_found_reg)
                        begin
                            res_next   = mk(ST_ABSENT, h_reg, '0, '0, count_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            mv_next    = fid_reg;
                            state_next = S_MVRD;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next   = mk(ST_EMPTY, h_reg, '0, '0, count_reg);
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_LKRD;
                        end
                    end
                    default:
                    begin
                        res_next   = mk(ST_OK, h_reg, '0, '0, count_reg);
                        state_next = S_OUT;
                    end
                endcase
            end
            S_MVRD:
            begin
                // add moves entries up from the top, remove moves them down
                if (op_reg == OP_ADD)
                begin
                    if (mv_reg > pos_reg)
                    begin
                        raddr      = AW'(mv_reg - CW'(1));
                        state_next = S_MVWR;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = AW'(pos_reg);
                        wdata      = {h_reg, key_reg};
                        count_next = count_reg + CW'(1);
                        res_next   = mk(ST_OK, h_reg, '0, '0, count_reg + CW'(1));
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    if (mv_reg + CW'(1) < count_reg)
                    begin
                        raddr      = AW'(mv_reg + CW'(1));
                        state_next = S_MVWR;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        res_next   = mk(ST_OK, h_reg, '0, '0, count_reg - CW'(1));
                        state_next = S_OUT;
                    end
                end
            end
            S_MVWR:
            begin
                we         = 1'b1;
                waddr      = AW'(mv_reg);
                wdata      = rdata;
                mv_next    = (op_reg == OP_ADD) ? mv_reg - CW'(1) : mv_reg + CW'(1);
                state_next = S_MVRD;
            end
            S_LKRD:
            begin
                raddr      = pos_found_reg ? AW'(pos_reg) : '0;
                state_next = S_LKWT;
            end
            S_LKWT:
            begin
                res_next   = mk(ST_OK, h_reg, rd_h, rd_id, count_reg);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
            chk_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
            chk_reg    <= chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        h_reg         <= h_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        pos_found_reg <= pos_found_next;
        hcol_reg      <= hcol_next;
        fid_reg       <= fid_next;
        fid_found_reg <= fid_found_next;
        mv_reg        <= mv_next;
        odata_reg     <= odata_next;
        res_reg       <= res_next;
    end

endmodule

`default_nettype wire

// ===== hdl/chr_ram.sv =====
// ----------------------------------------------------------------------------
// chr_ram: generic single-port-write, single-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/chr_hash.sv =====
// ----------------------------------------------------------------------------
// chr_hash: splitmix64 of the sign extended key, low 31 bits
// sequenced through states, one 32x32 partial product per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module chr_hash
    import chr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] key,
    output logic             done,
    output logic [30:0]      hash
);

    // only the low 64 bits of each product matter: lo*lo, lo*hi, hi*lo
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1A  = 4'd1;
    localparam logic [3:0] S_M1B  = 4'd2;
    localparam logic [3:0] S_M1C  = 4'd3;
    localparam logic [3:0] S_M2A  = 4'd4;
    localparam logic [3:0] S_M2B  = 4'd5;
    localparam logic [3:0] S_M2C  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0]  state_reg, state_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [63:0] mul_c;
    logic [63:0] sx;

    assign sx = {{32{key[31]}}, key} + MIX_GOLDEN;
    assign prod = {32'd0, ma} * {32'd0, mb};
    assign mul_c = (state_reg == S_M1A || state_reg == S_M1B || state_reg == S_M1C)
                   ? MIX_MUL_A : MIX_MUL_B;

    always_comb
    begin
        unique case (state_reg)
            S_M1A, S_M2A: begin ma = v_reg[31:0];  mb = mul_c[31:0];  end
            S_M1B, S_M2B: begin ma = v_reg[31:0];  mb = mul_c[63:32]; end
            default:      begin ma = v_reg[63:32]; mb = mul_c[31:0];  end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    v_next     = sx ^ (sx >> 30);
                    state_next = S_M1A;
                end
            end
            S_M1A, S_M2A:
            begin
                acc_next   = prod;
                state_next = state_reg + 4'd1;
            end
            S_M1B, S_M2B:
            begin
                acc_next   = acc_reg + {prod[31:0], 32'd0};
                state_next = state_reg + 4'd1;
            end
            S_M1C:
            begin
                acc_next   = acc_reg + {prod[31:0], 32'd0};
                v_next     = acc_next ^ (acc_next >> 27);
                state_next = S_M2A;
            end
            S_M2C:
            begin
                acc_next   = acc_reg + {prod[31:0], 32'd0};
                state_next = S_FIN;
            end
            S_FIN:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign hash = acc_reg[30:0] ^ acc_reg[61:31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        acc_reg <= acc_next;
    end

endmodule

`default_nettype wire

// ===== tb/chr_ring_checker.sv =====
// ----------------------------------------------------------------------------
// chr_ring_checker: scoreboard for the hash ring
// watches the cmd and rsp channels, models the sorted ring and compares
// every response word field by field against the predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chr_ring_checker
    import chr_pkg::*;
#(
    parameter int RING_SLOTS = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    chr_in_if.sink    cmd_mon,
    chr_out_if.sink   rsp_mon,
    output int        mismatch_count,
    output int        pending_count,
    output int        rsp_seen
);

    logic [30:0] ring_hash_m [RING_SLOTS];
    logic [31:0] ring_id_m   [RING_SLOTS];
    int          ring_len;
    out_word_t   rsp_queue [$];

    function automatic logic [30:0] splitmix31(logic [31:0] k);
        logic [63:0] v;
        v = {{32{k[31]}}, k};
        v = v + MIX_GOLDEN;
        v = (v ^ (v >> 30)) * MIX_MUL_A;
        v = (v ^ (v >> 27)) * MIX_MUL_B;
        v = v ^ (v >> 31);
        return v[30:0];
    endfunction

    task automatic apply_cmd(in_word_t w);
        out_word_t   r;
        logic [30:0] h;
        int          pos;
        int          idx;
        h = splitmix31(w.key);
        r = '0;
        r.key_hash = h;
        pos = ring_len;
        for (int i = ring_len - 1; i >= 0; i--)
            if (ring_hash_m[i] >= h) pos = i;
        idx = ring_len;
        for (int i = ring_len - 1; i >= 0; i--)
            if (ring_id_m[i] == w.key) idx = i;
        case (w.operation)
            OP_ADD:
            begin
                if (idx < ring_len) r.status = ST_ID_EXISTS;
                else if (pos < ring_len && ring_hash_m[pos] == h) r.status = ST_COLLISION;
                else if (ring_len >= RING_SLOTS) r.status = ST_FULL;
                else
                begin
                    for (int i = ring_len; i > pos; i--)
                    begin
                        ring_hash_m[i] = ring_hash_m[i-1];
                        ring_id_m[i]   = ring_id_m[i-1];
                    end
                    ring_hash_m[pos] = h;
                    ring_id_m[pos]   = w.key;
                    ring_len++;
                end
            end
            OP_REMOVE:
            begin
                if (idx >= ring_len) r.status = ST_ABSENT;
                else
                begin
                    for (int i = idx; i + 1 < ring_len; i++)
                    begin
                        ring_hash_m[i] = ring_hash_m[i+1];
                        ring_id_m[i]   = ring_id_m[i+1];
                    end
                    ring_len--;
                end
            end
            OP_LOOKUP:
            begin
                if (ring_len == 0) r.status = ST_EMPTY;
                else
                begin
                    if (pos >= ring_len) pos = 0;
                    r.owner_hash = ring_hash_m[pos];
                    r.owner_id   = ring_id_m[pos];
                end
            end
            default: ;
        endcase
        r.machine_count = ring_len[6:0];
        rsp_queue.insert(rsp_queue.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            ring_len = 0;
            rsp_queue.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
            rsp_seen       <= 0;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                rsp_seen <= rsp_seen + 1;
                if (rsp_queue.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected response word %h", rsp_mon.data);
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = rsp_queue.pop_front();
                    if (want !== rsp_mon.data)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: exp st=%0d kh=%h oh=%h oid=%h n=%0d",
                                     want.status, want.key_hash, want.owner_hash,
                                     want.owner_id, want.machine_count);
                            $display("          got st=%0d kh=%h oh=%h oid=%h n=%0d",
                                     rsp_mon.data.status, rsp_mon.data.key_hash,
                                     rsp_mon.data.owner_hash, rsp_mon.data.owner_id,
                                     rsp_mon.data.machine_count);
                        end
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
                apply_cmd(cmd_mon.data);
            pending_count <= rsp_queue.size();
        end
    end

endmodule

// ===== tb/consistent_hash_ring_top_tb.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_top_tb: stimulus for the hash ring
// directed corner words, then random add/remove/lookup and unused-opcode traffic with random
// gaps and back-pressure; the checker module does the scoring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module consistent_hash_ring_top_tb;
    import chr_pkg::*;

    localparam int SLOTS     = 64;
    localparam int N_RANDOM  = 1470;
    localparam int MAX_CYCLE = 4000000;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   pending;
    int   seen;
    int   cycle_count = 0;
    bit   hold_rsp;
    int   sent;
    logic [31:0] id_pool [128];

    chr_in_if  cmd_ch ();
    chr_out_if rsp_ch ();

    consistent_hash_ring_top #(.RING_SLOTS(SLOTS)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .rsp   (rsp_ch.source)
    );

    chr_ring_checker #(.RING_SLOTS(SLOTS)) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_mon        (cmd_ch.sink),
        .rsp_mon        (rsp_ch.sink),
        .mismatch_count (mismatches),
        .pending_count  (pending),
        .rsp_seen       (seen)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int g;
        bit held;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_rsp && !held)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
                held = 1'b1;
            end
            g = (seen > 600 && seen < 900) ? 0 : gap_len();
            if (g > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (g - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // called at a falling edge; ready only moves at rising edges
    task automatic send_word(logic [1:0] op, logic [31:0] k);
        int g;
        g = (sent > 300 && sent < 500) ? 0 : gap_len();
        if (g > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.data.operation <= op;
        cmd_ch.data.key       <= k;
        while (!cmd_ch.ready) @(negedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    initial
    begin
        int  op_pick;
        logic [1:0] op;
        logic [31:0] k;
        sent = 0;
        hold_rsp = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        for (int i = 0; i < 128; i++) id_pool[i] = $urandom();
        id_pool[0] = 32'h8000_0000;
        id_pool[1] = 32'h7fff_ffff;
        id_pool[2] = 32'h0;
        id_pool[3] = 32'hffff_ffff;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty ring cases, extremes, duplicate, last machine removal
        send_word(OP_LOOKUP, 32'h0);
        send_word(OP_REMOVE, 32'h1234);
        send_word(OP_ADD, 32'h8000_0000);
        send_word(OP_LOOKUP, 32'h7fff_ffff);
        send_word(OP_REMOVE, 32'h8000_0000);
        send_word(OP_LOOKUP, 32'hffff_ffff);
        send_word(OP_ADD, 32'h7fff_ffff);
        send_word(OP_ADD, 32'h7fff_ffff);
        send_word(OP_ADD, 32'h0);
        send_word(OP_ADD, 32'hffff_ffff);
        send_word(2'd3, 32'h5555_aaaa);
        send_word(2'd3, 32'haaaa_5555);
        send_word(OP_LOOKUP, 32'h0);
        send_word(OP_LOOKUP, 32'h8000_0000);
        send_word(OP_REMOVE, 32'h0);
        send_word(OP_REMOVE, 32'h0);
        // fill to full ring, then overflow
        for (int i = 0; i < SLOTS + 2; i++) send_word(OP_ADD, id_pool[i]);
        send_word(OP_LOOKUP, $urandom());
        // sender pause until everything is back
        drain();
        hold_rsp = 1'b1;

        for (int n = 0; n < N_RANDOM; n++)
        begin
            op_pick = $urandom_range(0, 99);
            if (op_pick < 35) op = OP_ADD;
            else if (op_pick < 65) op = OP_REMOVE;
            else if (op_pick < 97) op = OP_LOOKUP;
            else op = 2'd3;
            if (op == OP_LOOKUP || $urandom_range(0, 9) == 0) k = $urandom();
            else k = id_pool[$urandom_range(0, 127)];
            send_word(op, k);
            if (n == 800) drain();
        end
        drain();
        repeat (40) @(negedge clk);

        $display("covered %0d command words and %0d responses", sent, seen);
        $display("ring filled past capacity, emptied, with stalls on both channels");
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
